>>> sv/hsv_hue_recolor_pixel_core_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the HSV hue recolour core
// Shared property shorthands clocked on clk; the implication check is quiet during rst.
// ------------------------------------------------------------------------
`ifndef HSV_HUE_RECOLOR_PIXEL_CORE_MACROS_SVH
`define HSV_HUE_RECOLOR_PIXEL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define HSVR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after reset is seen high
`define HSVR_ASSERT_AFTER_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

>>> sv/hsvr_pkg.sv
// ------------------------------------------------------------------------
// hsvr_pkg
// Fixed-point formats, pipeline geometry and register codes.
// ------------------------------------------------------------------------
`default_nettype none

package hsvr_pkg;

  // fraction width of S, V and hue
  localparam int FRAC_BITS = 16;

  typedef logic [FRAC_BITS:0] frac_t;
  localparam frac_t ONE  = frac_t'(1) << FRAC_BITS;
  localparam frac_t HALF = frac_t'(1) << (FRAC_BITS - 1);

  localparam int PROD_W = 2 * FRAC_BITS + 2;
  localparam int HUE_W  = FRAC_BITS + 3;
  localparam int HSUM_W = FRAC_BITS + 4;
  typedef logic [HUE_W-1:0] hue_t;
  localparam logic [HSUM_W-1:0] HUE_FULL = HSUM_W'(6) << FRAC_BITS;

  // divider: one quotient bit per step, a few steps per stage
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int DIV_SPS    = 6;
  localparam int DIV_STAGES = (DIV_STEPS + DIV_SPS - 1) / DIV_SPS;

  localparam int ST_HSV      = DIV_STAGES + 1;
  localparam int ST_RGB      = DIV_STAGES + 2;
  localparam int ST_BLEND    = DIV_STAGES + 5;
  localparam int PIPE_STAGES = DIV_STAGES + 8;

  localparam logic [7:0]  CHAN_MAX    = 8'd255;
  localparam logic [15:0] BLEND_W     = 16'd65025;
  localparam logic [23:0] BLEND_HALF  = 24'd32512;
  localparam int          RECIP_SHIFT = 40;
  localparam logic [24:0] RECIP       = 25'((64'd1 << RECIP_SHIFT) / 64'd65025);

  typedef enum logic [2:0] {
    REG_TARGET_RED,
    REG_TARGET_GREEN,
    REG_TARGET_BLUE,
    REG_TARGET_ALPHA,
    REG_USE_MASK
  } cfg_reg_t;

  // round a product of two fractions back to one fraction
  function automatic frac_t rnd_frac(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] t;
    t = (p + PROD_W'(HALF)) >> FRAC_BITS;
    return t[FRAC_BITS:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/hsvr_div.sv
// ------------------------------------------------------------------------
// hsvr_div
// Pipelined restoring divider: round(num * ONE / den), num <= den.
// ------------------------------------------------------------------------
`default_nettype none

module hsvr_div (
  input  logic                               clk,
  input  logic [hsvr_pkg::DIV_STAGES-1:0]    en,
  input  logic [7:0]                         num,
  input  logic [7:0]                         den,
  output hsvr_pkg::frac_t                    quo
);

  logic [7:0]      rem [hsvr_pkg::DIV_STAGES];
  logic [7:0]      dq  [hsvr_pkg::DIV_STAGES];
  hsvr_pkg::frac_t qq  [hsvr_pkg::DIV_STAGES];

  for (genvar st = 0; st < hsvr_pkg::DIV_STAGES; st++) begin : g_st
    logic [7:0]      rem_in, rem_c, den_in;
    hsvr_pkg::frac_t q_in, q_c;

    if (st == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[st-1];
      assign den_in = dq[st-1];
      assign q_in   = qq[st-1];
    end

    always_comb begin
      logic [8:0]                       t;
      logic [hsvr_pkg::FRAC_BITS-1:0]   half;
      logic [hsvr_pkg::FRAC_BITS-1:0]   hb;
      int                               s;
      t     = '0;
      hb    = '0;
      half  = hsvr_pkg::FRAC_BITS'(den_in >> 1);
      rem_c = rem_in;
      q_c   = q_in;
      for (int k = 0; k < hsvr_pkg::DIV_SPS; k++) begin
        s = st * hsvr_pkg::DIV_SPS + k;
        if (s < hsvr_pkg::DIV_STEPS) begin
          // first step takes the whole integer part, the rest feed the rounding bits
          if (s == 0) begin
            t = {1'b0, num};
          end else begin
            hb = half >> (hsvr_pkg::FRAC_BITS - s);
            t  = {rem_c, hb[0]};
          end
          if (t >= {1'b0, den_in}) begin
            rem_c = 8'(t - {1'b0, den_in});
            q_c   = {q_c[hsvr_pkg::FRAC_BITS-1:0], 1'b1};
          end else begin
            rem_c = t[7:0];
            q_c   = {q_c[hsvr_pkg::FRAC_BITS-1:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[st]) begin
        rem[st] <= rem_c;
        dq[st]  <= den_in;
        qq[st]  <= q_c;
      end
    end
  end

  assign quo = qq[hsvr_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

>>> sv/hsvr_hsv2rgb.sv
// ------------------------------------------------------------------------
// hsvr_hsv2rgb
// Three-stage HSV to 8-bit RGB conversion.
// ------------------------------------------------------------------------
`default_nettype none

module hsvr_hsv2rgb (
  input  logic             clk,
  input  logic [2:0]       en,
  input  hsvr_pkg::frac_t  sat,
  input  hsvr_pkg::frac_t  val,
  input  hsvr_pkg::hue_t   hue,
  output logic [2:0][7:0]  rgb
);

  localparam int F = hsvr_pkg::FRAC_BITS;
  localparam int P = hsvr_pkg::PROD_W;

  // stage a
  hsvr_pkg::frac_t x_a, sf_a, sf1_a, v_a;
  logic            grey_a;
  logic [2:0]      sec_a;
  // stage b
  hsvr_pkg::frac_t x_b, y_b, z_b, v_b;
  logic            grey_b;
  logic [2:0]      sec_b;

  hsvr_pkg::frac_t  ch [3];
  logic [2:0][7:0]  rgb_next;

  hsvr_pkg::frac_t f_in;
  assign f_in = {1'b0, hue[F-1:0]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_a    <= hsvr_pkg::rnd_frac(P'(val) * P'(hsvr_pkg::ONE - sat));
      sf_a   <= hsvr_pkg::rnd_frac(P'(sat) * P'(f_in));
      sf1_a  <= hsvr_pkg::rnd_frac(P'(sat) * P'(hsvr_pkg::ONE - f_in));
      v_a    <= val;
      grey_a <= (sat == '0);
      sec_a  <= hue[F+2:F];
    end
    if (en[1]) begin
      x_b    <= x_a;
      y_b    <= hsvr_pkg::rnd_frac(P'(v_a) * P'(hsvr_pkg::ONE - sf_a));
      z_b    <= hsvr_pkg::rnd_frac(P'(v_a) * P'(hsvr_pkg::ONE - sf1_a));
      v_b    <= v_a;
      grey_b <= grey_a;
      sec_b  <= sec_a;
    end
    if (en[2]) begin
      rgb <= rgb_next;
    end
  end

  function automatic logic [7:0] to8(input hsvr_pkg::frac_t c);
    logic [F+8:0] t;
    t = ({c, 8'b0} - (F+9)'(c) + (F+9)'(hsvr_pkg::HALF)) >> F;
    return (t > (F+9)'(hsvr_pkg::CHAN_MAX)) ? hsvr_pkg::CHAN_MAX : t[7:0];
  endfunction

  always_comb begin
    if (grey_b) begin
      ch[0] = v_b; ch[1] = v_b; ch[2] = v_b;
    end else begin
      unique case (sec_b)
        3'd0: begin ch[0] = v_b; ch[1] = z_b; ch[2] = x_b; end
        3'd1: begin ch[0] = y_b; ch[1] = v_b; ch[2] = x_b; end
        3'd2: begin ch[0] = x_b; ch[1] = v_b; ch[2] = z_b; end
        3'd3: begin ch[0] = x_b; ch[1] = y_b; ch[2] = v_b; end
        3'd4: begin ch[0] = z_b; ch[1] = x_b; ch[2] = v_b; end
        default: begin ch[0] = v_b; ch[1] = x_b; ch[2] = y_b; end
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      rgb_next[k] = to8(ch[k]);
    end
  end

endmodule

`default_nettype wire

>>> sv/hsvr_blend.sv
// ------------------------------------------------------------------------
// hsvr_blend
// Three-stage weighted blend, rounded division by 65025.
// ------------------------------------------------------------------------
`default_nettype none

module hsvr_blend (
  input  logic             clk,
  input  logic [2:0]       en,
  input  logic [2:0][7:0]  src,
  input  logic [2:0][7:0]  rec,
  input  logic [15:0]      weight,
  output logic [2:0][7:0]  res
);

  logic [2:0][23:0] y1, y2;
  logic [2:0][8:0]  q2;
  logic [2:0][48:0] prod;
  logic [2:0][7:0]  res_next;

  always_comb begin
    logic [24:0] qw, r;
    qw = '0;
    r  = '0;
    for (int k = 0; k < 3; k++) begin
      prod[k] = 49'(y1[k]) * 49'(hsvr_pkg::RECIP);
      // estimate is exact or one short: one compare fixes it
      qw = {q2[k], 16'b0} - 25'({q2[k], 9'b0}) + 25'(q2[k]);
      r  = {1'b0, y2[k]} - qw;
      if (r >= 25'(hsvr_pkg::BLEND_W)) begin
        res_next[k] = 8'(q2[k] + 9'd1);
      end else begin
        res_next[k] = q2[k][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (en[0]) begin
        y1[k] <= 24'(src[k]) * 24'(hsvr_pkg::BLEND_W - weight)
               + 24'(rec[k]) * 24'(weight) + hsvr_pkg::BLEND_HALF;
      end
      if (en[1]) begin
        y2[k] <= y1[k];
        q2[k] <= prod[k][hsvr_pkg::RECIP_SHIFT+8:hsvr_pkg::RECIP_SHIFT];
      end
      if (en[2]) begin
        res[k] <= res_next[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/hsv_hue_recolor_pixel_core.sv
// ------------------------------------------------------------------------
// hsv_hue_recolor_pixel_core: HSV hue-replace recolour, one pixel a clock
// Throughput: one pixel per clock while m_axis_tready does not hold the
// output; the quotient-bit chains of the dividers set the depth (six bits
// per stage). rst clears the valid bits and the configuration registers;
// the data registers are not reset.
// ------------------------------------------------------------------------
`default_nettype none

module hsv_hue_recolor_pixel_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // pixel in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // in_red, in_green, in_blue, in_alpha, mask_level
  // pixel out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // out_red, out_green, out_blue, out_alpha
);

  `include "hsv_hue_recolor_pixel_core_macros.svh"

  localparam int N = hsvr_pkg::PIPE_STAGES;
  localparam int D = hsvr_pkg::DIV_STAGES;
  localparam int P = hsvr_pkg::PROD_W;
  localparam int F = hsvr_pkg::FRAC_BITS;

  // Per-pixel fields that ride alongside the arithmetic
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] weight;  // blend weight out of 65025
    logic [7:0]  p_max;   // source channel maximum
    logic [7:0]  t_max;   // target channel maximum
    logic        p_black; // source max is zero
    logic        t_grey;  // target has no chroma
    logic [2:0]  t_base;  // target hue sector base
    logic        t_neg;   // target hue offset is negative
  } side_t;

  // ---------------- configuration registers ----------------
  logic [7:0] target_red, target_green, target_blue, target_alpha;
  logic       use_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_red   <= '0;
      target_green <= '0;
      target_blue  <= '0;
      target_alpha <= '0;
      use_mask     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsvr_pkg::REG_TARGET_RED:   target_red   <= cfg_data;
        hsvr_pkg::REG_TARGET_GREEN: target_green <= cfg_data;
        hsvr_pkg::REG_TARGET_BLUE:  target_blue  <= cfg_data;
        hsvr_pkg::REG_TARGET_ALPHA: target_alpha <= cfg_data;
        hsvr_pkg::REG_USE_MASK:     use_mask     <= cfg_data[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // A stage advances when it is empty or the stage after it advances, so
  // bubbles collapse and input fills empty stages while the output waits.
  logic [N-1:0] vld, en;

  always_comb begin
    en[N-1] = !vld[N-1] || m_axis_tready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------- stage 0: max, min, delta, weight ----------------
  logic [7:0] in_red, in_green, in_blue, in_alpha, mask_level;
  assign in_red     = s_axis_tdata[7:0];
  assign in_green   = s_axis_tdata[15:8];
  assign in_blue    = s_axis_tdata[23:16];
  assign in_alpha   = s_axis_tdata[31:24];
  assign mask_level = s_axis_tdata[39:32];

  logic [7:0] p_max_c, p_min_c, t_max_c, t_min_c, t_pos, t_neg_v;
  logic [2:0] t_base_c;
  side_t      side_in;

  always_comb begin
    p_max_c = in_red;
    if (in_green > p_max_c) p_max_c = in_green;
    if (in_blue > p_max_c)  p_max_c = in_blue;
    p_min_c = in_red;
    if (in_green < p_min_c) p_min_c = in_green;
    if (in_blue < p_min_c)  p_min_c = in_blue;

    t_max_c = target_red;
    if (target_green > t_max_c) t_max_c = target_green;
    if (target_blue > t_max_c)  t_max_c = target_blue;
    t_min_c = target_red;
    if (target_green < t_min_c) t_min_c = target_green;
    if (target_blue < t_min_c)  t_min_c = target_blue;

    // hue numerator follows whichever channel holds the maximum, red first
    priority if (target_red == t_max_c) begin
      t_pos = target_green; t_neg_v = target_blue;  t_base_c = 3'd0;
    end else if (target_green == t_max_c) begin
      t_pos = target_blue;  t_neg_v = target_red;   t_base_c = 3'd2;
    end else begin
      t_pos = target_red;   t_neg_v = target_green; t_base_c = 3'd4;
    end

    side_in.red     = in_red;
    side_in.green   = in_green;
    side_in.blue    = in_blue;
    side_in.alpha   = in_alpha;
    // unmasked alpha is scaled by 255 so both modes divide by 65025
    side_in.weight  = use_mask ? 16'(mask_level) * 16'(target_alpha)
                               : {target_alpha, 8'b0} - 16'(target_alpha);
    side_in.p_max   = p_max_c;
    side_in.t_max   = t_max_c;
    side_in.p_black = (p_max_c == '0);
    side_in.t_grey  = (t_max_c == t_min_c);
    side_in.t_base  = t_base_c;
    side_in.t_neg   = (t_pos < t_neg_v);
  end

  logic [7:0] p_max, p_delta, t_max, t_delta, t_hnum;
  side_t      side [N];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_max   <= p_max_c;
      p_delta <= p_max_c - p_min_c;
      t_max   <= t_max_c;
      t_delta <= t_max_c - t_min_c;
      t_hnum  <= (t_pos < t_neg_v) ? t_neg_v - t_pos : t_pos - t_neg_v;
      side[0] <= side_in;
    end
    for (int i = 1; i < N; i++) begin
      if (en[i]) side[i] <= side[i-1];
    end
  end

  // ---------------- stages 1..D: dividers ----------------
  hsvr_pkg::frac_t q_ps, q_ts, q_th;

  hsvr_div u_div_ps (.clk(clk), .en(en[D:1]), .num(p_delta), .den(p_max),   .quo(q_ps));
  hsvr_div u_div_ts (.clk(clk), .en(en[D:1]), .num(t_delta), .den(t_max),   .quo(q_ts));
  hsvr_div u_div_th (.clk(clk), .en(en[D:1]), .num(t_hnum),  .den(t_delta), .quo(q_th));

  // channel level to value fraction, rnd(c * ONE / 255), a table of constants
  hsvr_pkg::frac_t v_lut [256];
  for (genvar k = 0; k < 256; k++) begin : g_vlut
    assign v_lut[k] = hsvr_pkg::frac_t'(((longint'(k) << F) + 127) / 255);
  end

  // ---------------- stage D+1: scale S and V, place target hue ----------------
  hsvr_pkg::frac_t     sp, st, pv, tv;
  logic [F+3:0]        hb, hsum;
  hsvr_pkg::hue_t      ht_c;
  hsvr_pkg::frac_t     sn, vn;
  hsvr_pkg::hue_t      ht;

  always_comb begin
    pv   = v_lut[side[D].p_max];
    tv   = v_lut[side[D].t_max];
    // a zero divisor leaves junk in the quotient: force zero saturation
    sp   = side[D].p_black ? '0 : q_ps;
    st   = side[D].t_grey  ? '0 : q_ts;
    hb   = (F+4)'(side[D].t_base) << F;
    hsum = side[D].t_neg ? hb + hsvr_pkg::HUE_FULL - (F+4)'(q_th)
                         : hb + hsvr_pkg::HUE_FULL + (F+4)'(q_th);
    if (hsum >= hsvr_pkg::HUE_FULL) hsum = hsum - hsvr_pkg::HUE_FULL;
    ht_c = side[D].t_grey ? '0 : hsum[F+2:0];
  end

  always_ff @(posedge clk) begin
    if (en[hsvr_pkg::ST_HSV]) begin
      sn <= hsvr_pkg::rnd_frac(P'(sp) * P'(st));
      vn <= hsvr_pkg::rnd_frac(P'(pv) * P'(tv));
      ht <= ht_c;
    end
  end

  // ---------------- stages D+2..D+4: back to RGB ----------------
  logic [2:0][7:0] rec8;

  hsvr_hsv2rgb u_hsv2rgb (
    .clk (clk),
    .en  (en[hsvr_pkg::ST_RGB+2:hsvr_pkg::ST_RGB]),
    .sat (sn),
    .val (vn),
    .hue (ht),
    .rgb (rec8)
  );

  // ---------------- stages D+5..D+7: blend, output register ----------------
  logic [2:0][7:0] src8, res8;
  assign src8 = {side[hsvr_pkg::ST_BLEND-1].blue, side[hsvr_pkg::ST_BLEND-1].green,
                 side[hsvr_pkg::ST_BLEND-1].red};

  hsvr_blend u_blend (
    .clk    (clk),
    .en     (en[hsvr_pkg::ST_BLEND+2:hsvr_pkg::ST_BLEND]),
    .src    (src8),
    .rec    (rec8),
    .weight (side[hsvr_pkg::ST_BLEND-1].weight),
    .res    (res8)
  );

  assign m_axis_tvalid = vld[N-1];
  assign m_axis_tdata  = {side[N-1].alpha, res8[2], res8[1], res8[0]};

  // ---------------- assertions ----------------
  // Input only stalls when a finished pixel is held at the output
  `HSVR_ASSERT_IMP(a_stall_from_output, !s_axis_tready,
                   m_axis_tvalid && !m_axis_tready, "input stalled without output hold")
  // Zero blend weight must return the source pixel untouched
  `HSVR_ASSERT_IMP(a_zero_weight_passes, m_axis_tvalid && side[N-1].weight == '0,
                   m_axis_tdata[7:0] == side[N-1].red &&
                   m_axis_tdata[15:8] == side[N-1].green &&
                   m_axis_tdata[23:16] == side[N-1].blue, "zero weight altered pixel")
  // Reset empties the pipeline
  `HSVR_ASSERT_AFTER_RST(a_reset_empty, !m_axis_tvalid, "output valid after reset")

endmodule

`default_nettype wire
